// ===== design/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, constants and helper functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned BlockWords  = 16;
   localparam int unsigned HashWords   = 8;
   localparam int unsigned RoundCount  = 64;
   localparam int unsigned BlockAw     = 4;
   localparam int unsigned HashAw      = 3;

   typedef logic [1:0] command_type;
   localparam command_type CmdAbsorb       = 2'd0;
   localparam command_type CmdAbsorbFinish = 2'd1;
   localparam command_type CmdFinish       = 2'd2;
   localparam command_type CmdUnused       = 2'd3;

   localparam logic [7:0] PadByte = 8'h80;

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[idx];
   endfunction

   function automatic logic [31:0] init_h(input logic [2:0] idx);
      logic [31:0] h [8];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[idx];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   // Working variables a..h
   typedef struct packed {
      logic [31:0] a, b, c, d, e, f, g, h;
   } work_type;

   // Sequencer controls toward the round datapath
   typedef struct packed {
      logic        load;    // load a..h from hash words
      logic        round;   // perform one round
      logic [31:0] w;       // schedule word for this round
      logic [5:0]  ridx;    // round index
   } round_ctl_type;

endpackage

`default_nettype wire

// ===== design/sha256_stream_hasher_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher core
// Byte-wide SHA-256 engine with in-line padding and word-serial digest output.
// ----------------------------------------------------------------------------
// Requests carry one byte each. A byte that does not complete a block is taken
// as a read-modify-write of the block memory. A byte that fills the block
// starts a compression: the hash words are read into a..h, a wait state covers
// the block memory read, 64 rounds run one per cycle (the first 16 take their
// words straight from the block memory), and the eight sums are fed forward
// into the hash memory. A finish pads the block byte by byte, writes the bit
// count, runs one or two compressions, then reads out the eight digest words,
// each read, captured and held until the receiver is ready; after the last one
// the hash memory reads as the initial hash values again. The block memory and
// the hash memory are single-port-read RAMs with registered reads, which set
// this sequence. After reset the block is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [1:0] command, [9:2] data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [31:0] digest_word, [34:32] word_index
   output logic             rsp_tlast
);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_BYTE   = 12'b000000000010,  // block word read returned, merge byte
      S_PAD    = 12'b000000000100,  // issue read for next padding byte
      S_PADW   = 12'b000000001000,  // merge padding byte
      S_LEN    = 12'b000000010000,  // write length words
      S_HLOAD  = 12'b000000100000,  // read hash words into a..h
      S_WLOAD  = 12'b000001000000,  // rounds 0..15 from block memory
      S_ROUND  = 12'b000010000000,  // rounds 16..63
      S_FEED   = 12'b000100000000,  // feed-forward into hash memory
      S_OUTRD  = 12'b001000000000,  // read digest word
      S_OUT    = 12'b010000000000,  // present digest word
      S_WAIT   = 12'b100000000000   // block memory read wait before round 0
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic        fin_ff, fin_in;       // finish pending after compression
   logic        padding_ff, padding_in; // compression is part of padding
   logic        lenpend_ff, lenpend_in; // length block still to run
   logic [7:0]  byte_ff, byte_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        hinit_ff, hinit_in;   // hash memory content is stale: read as H0
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] hcap_ff [8];
   logic [31:0] hcap_in [8];
   logic [31:0] out_ff, out_in;
   logic [2:0]  oidx_ff, oidx_in;

   // Block memory
   logic        bm_we;
   logic [3:0]  bm_wa, bm_ra;
   logic [31:0] bm_wd, bm_rd;
   // Hash memory
   logic        hm_we;
   logic [2:0]  hm_wa, hm_ra;
   logic [31:0] hm_wd, hm_rd, hm_val;

   sha256_pkg::round_ctl_type rctl;
   sha256_pkg::work_type      rinit, rwork;

   sha256_ram #(.Width(sha256_pkg::WordWidth), .Depth(sha256_pkg::BlockWords)) u_block (
      .clock(clock), .wr_en(bm_we), .wr_addr(bm_wa), .wr_data(bm_wd),
      .rd_addr(bm_ra), .rd_data(bm_rd));

   sha256_ram #(.Width(sha256_pkg::WordWidth), .Depth(sha256_pkg::HashWords)) u_hash (
      .clock(clock), .wr_en(hm_we), .wr_addr(hm_wa), .wr_data(hm_wd),
      .rd_addr(hm_ra), .rd_data(hm_val));

   sha256_round u_round (.clock(clock), .ctl(rctl), .init(rinit), .work(rwork));

   logic [1:0]  cmd;
   logic [31:0] merged, wnext;
   logic [4:0]  shamt;
   logic [3:0]  rd_slot;
   logic [2:0]  hsel;

   assign cmd = req_tdata[1:0];
   // Hash memory reads as H0 until a block has fed forward into it
   assign hm_rd = hinit_ff ? sha256_pkg::init_h(hsel) : hm_val;

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      fin_in     = fin_ff;
      padding_in = padding_ff;
      lenpend_in = lenpend_ff;
      byte_in    = byte_ff;
      cnt_in     = cnt_ff;
      hinit_in   = hinit_ff;
      w_in       = w_ff;
      hcap_in    = hcap_ff;
      out_in     = out_ff;
      oidx_in    = oidx_ff;
      bm_we = 1'b0; bm_wa = fill_ff[5:2]; bm_wd = '0; bm_ra = fill_ff[5:2];
      hm_we = 1'b0; hm_wa = cnt_ff[2:0]; hm_wd = '0; hm_ra = cnt_ff[2:0];
      hsel  = 3'(cnt_ff[2:0] - 3'd1);
      req_tready = 1'b0;
      rctl = '0;
      rctl.ridx = cnt_ff[5:0];
      rinit = '0;
      shamt = 5'(5'd24 - {fill_ff[1:0], 3'b000});
      merged = (fill_ff[1:0] == 2'd0) ? ({24'd0, byte_ff} << shamt)
             : ((bm_rd & ~(32'hff << shamt)) | ({24'd0, byte_ff} << shamt));
      rd_slot = 4'(cnt_ff[3:0] + 4'd1);
      wnext = sha256_pkg::small_s1(w_ff[14]) + w_ff[9]
            + sha256_pkg::small_s0(w_ff[1]) + w_ff[0];

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            byte_in = req_tdata[9:2];
            if (req_tvalid) begin
               case (cmd)
                  sha256_pkg::CmdAbsorb, sha256_pkg::CmdAbsorbFinish: begin
                     fin_in = (cmd == sha256_pkg::CmdAbsorbFinish);
                     state_in = S_BYTE;
                  end
                  sha256_pkg::CmdFinish: begin
                     byte_in = sha256_pkg::PadByte;
                     fin_in = 1'b1;
                     padding_in = 1'b1;
                     state_in = S_PAD;
                  end
                  default: ;
               endcase
            end
         end
         // Merge the message byte into its block word
         S_BYTE: begin
            bm_we = 1'b1; bm_wd = merged;
            bits_in = bits_ff + 64'd8;
            fill_in = 6'(fill_ff + 6'd1);
            if (fill_ff == 6'd63) begin
               cnt_in = '0; state_in = S_HLOAD;
            end else if (fin_ff) begin
               byte_in = sha256_pkg::PadByte; padding_in = 1'b1; state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            state_in = S_PADW;
         end
         // Write one padding byte, decide what follows
         S_PADW: begin
            bm_we = 1'b1; bm_wd = merged;
            byte_in = 8'h00;
            fill_in = 6'(fill_ff + 6'd1);
            if (fill_ff == 6'd63) begin
               lenpend_in = 1'b1; cnt_in = '0; state_in = S_HLOAD;
            end else if (fill_ff == 6'd55) begin
               cnt_in = '0; state_in = S_LEN;
            end else begin
               state_in = S_PAD;
            end
         end
         // Write the big-endian bit count into words 14 and 15
         S_LEN: begin
            bm_we = 1'b1;
            if (cnt_ff[0] == 1'b0) begin
               bm_wa = 4'd14; bm_wd = bits_ff[63:32]; cnt_in = 7'd1;
            end else begin
               bm_wa = 4'd15; bm_wd = bits_ff[31:0];
               lenpend_in = 1'b0; fill_in = '0; cnt_in = '0; state_in = S_HLOAD;
            end
         end
         // Read hash words into a capture row, then load a..h
         S_HLOAD: begin
            hm_ra = cnt_ff[2:0];
            if (cnt_ff != 7'd0) begin
               hcap_in[hsel] = hm_rd;
            end
            if (cnt_ff == 7'd8) begin
               rinit = {hcap_ff[0], hcap_ff[1], hcap_ff[2], hcap_ff[3],
                        hcap_ff[4], hcap_ff[5], hcap_ff[6], hm_rd};
               rctl.load = 1'b1;
               bm_ra = 4'd0;
               cnt_in = '0;
               state_in = S_WAIT;
            end else begin
               cnt_in = 7'(cnt_ff + 7'd1);
            end
         end
         // Issue the read of block word 0 for round 0
         S_WAIT: begin
            bm_ra = 4'd0;
            state_in = S_WLOAD;
         end
         // Rounds 0..15 use block words straight from memory
         S_WLOAD: begin
            bm_ra = rd_slot;
            rctl.round = 1'b1; rctl.w = bm_rd;
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
            w_in[15] = bm_rd;
            cnt_in = 7'(cnt_ff + 7'd1);
            if (cnt_ff == 7'd15) state_in = S_ROUND;
         end
         // Rounds 16..63 extend the schedule window
         S_ROUND: begin
            rctl.round = 1'b1; rctl.w = wnext;
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
            w_in[15] = wnext;
            cnt_in = 7'(cnt_ff + 7'd1);
            if (cnt_ff == 7'd63) begin
               cnt_in = '0; state_in = S_FEED;
            end
         end
         // Add working variables back into the hash memory
         S_FEED: begin
            hm_we = 1'b1; hm_wa = cnt_ff[2:0];
            case (cnt_ff[2:0])
               3'd0: hm_wd = hcap_ff[0] + rwork.a;
               3'd1: hm_wd = hcap_ff[1] + rwork.b;
               3'd2: hm_wd = hcap_ff[2] + rwork.c;
               3'd3: hm_wd = hcap_ff[3] + rwork.d;
               3'd4: hm_wd = hcap_ff[4] + rwork.e;
               3'd5: hm_wd = hcap_ff[5] + rwork.f;
               3'd6: hm_wd = hcap_ff[6] + rwork.g;
               default: hm_wd = hcap_ff[7] + rwork.h;
            endcase
            if (cnt_ff == 7'd7) hcap_in[7] = hm_wd;
            cnt_in = 7'(cnt_ff + 7'd1);
            if (cnt_ff == 7'd7) begin
               hinit_in = 1'b0;
               cnt_in = '0;
               if (lenpend_ff) begin
                  byte_in = 8'h00; state_in = S_PAD;
               end else if (padding_ff) begin
                  oidx_in = '0; state_in = S_OUTRD;
               end else if (fin_ff) begin
                  byte_in = sha256_pkg::PadByte; padding_in = 1'b1; state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_OUTRD: begin
            hm_ra = oidx_ff;
            cnt_in = 7'd1;
            state_in = S_OUT;
         end
         // Present the digest word; drop after handshake
         S_OUT: begin
            hsel = oidx_ff;
            if (cnt_ff == 7'd1) begin
               out_in = hm_rd; cnt_in = '0;
            end else if (rsp_tready) begin
               oidx_in = 3'(oidx_ff + 3'd1);
               if (oidx_ff == 3'd7) begin
                  hinit_in = 1'b1; fill_in = '0; bits_in = '0;
                  fin_in = 1'b0; padding_in = 1'b0; state_in = S_IDLE;
               end else begin
                  state_in = S_OUTRD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = (state_ff == S_OUT) && (cnt_ff == 7'd0);
   assign rsp_tdata  = {5'd0, oidx_ff, out_ff};
   assign rsp_tlast  = (oidx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fill_ff    <= '0;
         bits_ff    <= '0;
         fin_ff     <= 1'b0;
         padding_ff <= 1'b0;
         lenpend_ff <= 1'b0;
         cnt_ff     <= '0;
         hinit_ff   <= 1'b1;
         oidx_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         bits_ff    <= bits_in;
         fin_ff     <= fin_in;
         padding_ff <= padding_in;
         lenpend_ff <= lenpend_in;
         cnt_ff     <= cnt_in;
         hinit_ff   <= hinit_in;
         oidx_ff    <= oidx_in;
      end
      byte_ff <= byte_in;
      w_ff    <= w_in;
      hcap_ff <= hcap_in;
      out_ff  <= out_in;
   end

endmodule

`default_nettype wire

// ===== design/sha256_ram.sv =====
// ----------------------------------------------------------------------------
// SHA-256 generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // Write, then register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/sha256_round.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round datapath
// Holds the working variables a..h and performs one compression round a cycle while ctl.round is set.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_round (
   input  wire logic                     clock,
   input  wire sha256_pkg::round_ctl_type ctl,
   input  wire sha256_pkg::work_type     init,
   output sha256_pkg::work_type          work
);

   sha256_pkg::work_type work_ff, work_in;
   logic [31:0] t1, t2;

   // Compute the round terms
   always_comb begin
      t1 = work_ff.h + sha256_pkg::big_s1(work_ff.e)
         + ((work_ff.e & work_ff.f) ^ (~work_ff.e & work_ff.g))
         + sha256_pkg::round_k(ctl.ridx) + ctl.w;
      t2 = sha256_pkg::big_s0(work_ff.a)
         + ((work_ff.a & work_ff.b) ^ (work_ff.a & work_ff.c) ^ (work_ff.b & work_ff.c));
      work_in = work_ff;
      if (ctl.load) begin
         work_in = init;
      end else if (ctl.round) begin
         work_in.h = work_ff.g;
         work_in.g = work_ff.f;
         work_in.f = work_ff.e;
         work_in.e = work_ff.d + t1;
         work_in.d = work_ff.c;
         work_in.c = work_ff.b;
         work_in.b = work_ff.a;
         work_in.a = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign work = work_ff;

endmodule

`default_nettype wire
